// File: hw/rtl/lkvc_pkg.sv
package lkvc_pkg;

  // Field widths fixed by the item format
  localparam int unsigned KEY_IN_W  = 31;
  localparam int unsigned VAL_W     = 31;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned CAP_RESET = 16;

  // Request kinds
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_AGE,
    ST_WRITE,
    ST_DONE
  } lkvc_state_e;

endpackage

// File: hw/rtl/lru_key_value_cache.sv
// Each item makes a lookup pass over the single-port entry memories; every item
// but a get that misses then makes a recency update pass and a write. No new
// item is taken until the last has finished (in_stall_o is high outside idle);
// a result still stalled at the output holds the finished item in ST_DONE.
// Reset (rst_ni low, asynchronous) empties the store and sets capacity to 16.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CAP_W-1:0]    cfg_wdata_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [KEY_IN_W-1:0] lookup_key_i,
  input  logic [VAL_W-1:0]    put_value_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                key_found_o,
  output logic [VAL_W-1:0]    read_value_o
);

  // Stored key width: keys compare in their low KW bits (KEY_BITS, capped at KEY_IN_W)
  localparam int unsigned KW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  // Entry index width, also the recency rank width (ranks run 0..ENTRIES-1)
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // Counter width: holds ENTRIES itself (scan counter and fill count)
  localparam int unsigned NW = $clog2(ENTRIES + 1);
  // Width for the capacity compare
  localparam int unsigned CW = (NW > CAP_W) ? NW : CAP_W;

  // ---------------------------------------------------------------------------
  // Entry storage. Keys, values and ranks live in single-port memories with a
  // registered read; all three share one read address driven by the scan
  // counter. Valid bits are flops so reset empties the store at once.
  // ---------------------------------------------------------------------------
  logic [KW-1:0]    key_mem  [ENTRIES];
  logic [VAL_W-1:0] val_mem  [ENTRIES];
  logic [IW-1:0]    rank_mem [ENTRIES];

  logic [KW-1:0]    key_rd_q;
  logic [VAL_W-1:0] val_rd_q;
  logic [IW-1:0]    rank_rd_q;

  logic [ENTRIES-1:0] valid_q;
  logic [NW-1:0]      fill_q;
  logic [CAP_W-1:0]   cap_q;

  // Sequencer
  lkvc_state_e state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] cnt_m1;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] eidx;

  // Captured request
  logic          put_q;
  logic [KW-1:0] key_q;
  logic [VAL_W-1:0] pval_q;

  // Lookup pass results
  logic             hit_q;
  logic [IW-1:0]    hit_idx_q;
  logic [IW-1:0]    hit_rank_q;
  logic [VAL_W-1:0] hit_val_q;
  logic             free_q;
  logic [IW-1:0]    free_idx_q;
  logic             vic_q;
  logic [IW-1:0]    vic_idx_q;
  logic [IW-1:0]    vic_rank_q;

  // Update plan
  logic [IW-1:0] tgt_q;
  logic [IW-1:0] tgt_rank_q;
  logic          age_all_q;
  logic          fill_new_q;

  // Result and output register
  logic             res_found_q;
  logic [VAL_W-1:0] res_val_q;
  logic             out_valid_q;
  logic             out_found_q;
  logic [VAL_W-1:0] out_val_q;

  // Control strobes
  logic accept;
  logic scan_eval;
  logic age_eval;
  logic age_we;
  logic load_out;
  logic fill_ok;
  logic evict;
  logic do_update;

  logic [CW-1:0] eff_cap;
  logic          e_valid;

  // Effective capacity: zero means one, anything above ENTRIES saturates
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(cap_q) > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = CW'(cap_q);
    end
  end

  // The counter issues the read for entry cnt; data for entry cnt-1 is back
  assign cnt_m1  = cnt_q - NW'(1);
  assign eidx    = cnt_m1[IW-1:0];
  assign rd_idx  = (cnt_q < NW'(ENTRIES)) ? cnt_q[IW-1:0] : '0;
  assign e_valid = valid_q[eidx];

  // Decision on a miss: fill a free slot while under capacity, else evict
  assign fill_ok   = put_q && !hit_q && (CW'(fill_q) < eff_cap) && free_q;
  assign evict     = put_q && !hit_q && !fill_ok && vic_q;
  assign do_update = hit_q || fill_ok || evict;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_q == NW'(ENTRIES)) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = do_update ? ST_AGE : ST_DONE;
      end
      ST_AGE: begin
        if (cnt_q == NW'(ENTRIES)) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    accept    = 1'b0;
    scan_eval = 1'b0;
    age_eval  = 1'b0;
    load_out  = 1'b0;
    cnt_d     = cnt_q;
    case (state_q)
      ST_IDLE: begin
        accept = in_valid_i;
        cnt_d  = '0;
      end
      ST_SCAN: begin
        scan_eval = (cnt_q != '0);
        if (cnt_q != NW'(ENTRIES)) cnt_d = cnt_q + NW'(1);
      end
      ST_DECIDE: begin
        cnt_d = '0;
      end
      ST_AGE: begin
        age_eval = (cnt_q != '0);
        if (cnt_q != NW'(ENTRIES)) cnt_d = cnt_q + NW'(1);
      end
      ST_WRITE: begin
        cnt_d = cnt_q;
      end
      ST_DONE: begin
        load_out = !out_valid_q || !out_stall_i;
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  // Age a valid entry younger than the target; on a fill, age every valid one
  assign age_we = age_eval && e_valid && (eidx != tgt_q) &&
                  (age_all_q || (rank_rd_q < tgt_rank_q));

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign key_found_o  = out_found_q;
  assign read_value_o = out_val_q;

  // ---------------------------------------------------------------------------
  // Memories: one read and one write per cycle, read data registered
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[rd_idx];
    val_rd_q  <= val_mem[rd_idx];
    rank_rd_q <= rank_mem[rd_idx];
    if (state_q == ST_WRITE) begin
      // Replace key and value on a fill or eviction; overwrite value on a put hit
      if (fill_new_q || !hit_q) key_mem[tgt_q] <= key_q;
      if (put_q) val_mem[tgt_q] <= pval_q;
      rank_mem[tgt_q] <= '0;
    end else if (age_we) begin
      rank_mem[eidx] <= rank_rd_q + IW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      fill_q      <= '0;
      cap_q       <= CAP_W'(CAP_RESET);
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      vic_q       <= 1'b0;
      age_all_q   <= 1'b0;
      fill_new_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;

      if (accept) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        vic_q  <= 1'b0;
      end
      if (scan_eval) begin
        if (e_valid && (key_rd_q == key_q) && !hit_q) hit_q <= 1'b1;
        if (!e_valid && !free_q) free_q <= 1'b1;
        if (e_valid && (!vic_q || (rank_rd_q > vic_rank_q))) vic_q <= 1'b1;
      end

      if (state_q == ST_DECIDE) begin
        age_all_q  <= fill_ok;
        fill_new_q <= fill_ok;
      end

      if (state_q == ST_WRITE && fill_new_q) begin
        valid_q[tgt_q] <= 1'b1;
        fill_q         <= fill_q + NW'(1);
      end

      // Output register: drop on take, refill from the finished item
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      put_q  <= (req_type_i == REQ_PUT);
      key_q  <= lookup_key_i[KW-1:0];
      pval_q <= put_value_i;
    end

    if (scan_eval) begin
      // First matching entry wins
      if (e_valid && (key_rd_q == key_q) && !hit_q) begin
        hit_idx_q  <= eidx;
        hit_rank_q <= rank_rd_q;
        hit_val_q  <= val_rd_q;
      end
      // Lowest-indexed free slot
      if (!e_valid && !free_q) free_idx_q <= eidx;
      // Oldest valid entry, lowest index on a tie
      if (e_valid && (!vic_q || (rank_rd_q > vic_rank_q))) begin
        vic_idx_q  <= eidx;
        vic_rank_q <= rank_rd_q;
      end
    end

    if (state_q == ST_DECIDE) begin
      res_found_q <= hit_q;
      res_val_q   <= (hit_q && !put_q) ? hit_val_q : '0;
      if (hit_q) begin
        tgt_q      <= hit_idx_q;
        tgt_rank_q <= hit_rank_q;
      end else if (fill_ok) begin
        tgt_q      <= free_idx_q;
        tgt_rank_q <= '0;
      end else begin
        tgt_q      <= vic_idx_q;
        tgt_rank_q <= vic_rank_q;
      end
    end

    if (load_out) begin
      out_found_q <= res_found_q;
      out_val_q   <= res_val_q;
    end
  end

endmodule
